// ===== rtl/core/tds_pkg.sv =====
// Package for the tridiagonal system solver: widths, error codes and
// the fixed-point helpers shared by the solver core and the divider.
// No dependencies.
package tds_pkg;

    localparam int DATA_W        = 32;
    localparam int ROW_IDX_W     = 6;
    localparam int ERR_W         = 2;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PIVOT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ROWS  = 2'd2;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // a - b, saturated to 32 bits signed
    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] d;
        begin
            d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
            if (d[DATA_W] != d[DATA_W-1])
                sat_sub = d[DATA_W] ? Q_MIN : Q_MAX;
            else
                sat_sub = d[DATA_W-1:0];
        end
    endfunction

    // round half up, floor shift by frac, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] round_mul(
        input logic signed [2*DATA_W-1:0] p,
        input int                         frac
    );
        logic signed [2*DATA_W-1:0] r;
        logic                       hi_ones;
        logic                       hi_zeros;
        begin
            r        = (p + (64'sd1 <<< (frac - 1))) >>> frac;
            hi_ones  = &r[2*DATA_W-1:DATA_W-1];
            hi_zeros = ~|r[2*DATA_W-1:DATA_W-1];
            if (hi_ones || hi_zeros)
                round_mul = r[DATA_W-1:0];
            else
                round_mul = r[2*DATA_W-1] ? Q_MIN : Q_MAX;
        end
    endfunction

endpackage

// ===== rtl/core/tds_div.sv =====
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to 32 bits. Depends on tds_pkg.
module tds_div #(
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [tds_pkg::DATA_W-1:0]  num,
    input  logic signed [tds_pkg::DATA_W-1:0]  den,
    output logic                               done,
    output logic signed [tds_pkg::DATA_W-1:0]  quo
);
    import tds_pkg::*;

    localparam int W     = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(W + 1);

    logic                     busy_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [W-1:0]             dvd_reg;
    logic [DATA_W-1:0]        dmag_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [DATA_W:0]          rem_sh;
    logic                     ge;
    logic [DATA_W:0]          rem_diff;
    logic [DATA_W-1:0]        nmag;
    logic                     big_pos;
    logic                     big_neg;

    assign rem_sh   = {rem_reg, dvd_reg[W-1]};
    assign ge       = rem_sh >= {1'b0, dmag_reg};
    assign rem_diff = rem_sh - {1'b0, dmag_reg};
    assign nmag     = num[DATA_W-1] ? (~num + 1'b1) : num;
    assign big_pos  = |dvd_reg[W-1:DATA_W-1];
    assign big_neg  = (|dvd_reg[W-1:DATA_W]) || (dvd_reg[DATA_W-1] && |dvd_reg[DATA_W-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(W);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
            dmag_reg <= den[DATA_W-1] ? (~den + 1'b1) : den;
            dvd_reg  <= {nmag, {FRAC_BITS{1'b0}}};
            rem_reg  <= '0;
            if (num[DATA_W-1])
                quo_reg <= Q_MIN;
            else if (num == '0)
                quo_reg <= '0;
            else
                quo_reg <= Q_MAX;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            dvd_reg <= {dvd_reg[W-2:0], ge};
        end
        else if (fin_reg)
        begin
            if (neg_reg)
                quo_reg <= big_neg ? Q_MIN : (~dvd_reg[DATA_W-1:0] + 1'b1);
            else
                quo_reg <= big_pos ? Q_MAX : dvd_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    ap_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && fin_reg)) else $error("divider busy and finishing together");
    ap_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg && !start |=> done_reg) else $error("divider finish lost");
    ap_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0) else $error("divider count ran out while busy");

endmodule

// ===== rtl/core/tridiagonal_system_solver.sv =====
// Tridiagonal solver (Thomas algorithm), signed Q(32-F).F with saturation. Rows stream
// in one per transfer; elimination runs as each row loads: a serial divide for the
// multiplier, then multiply, round and subtract for the pivot and again for the forward
// value, then a store (row 0 is stored directly). After the row marked tlast, solutions
// come out from the last index down to 0, each through the shared divider and multiplier;
// tready is low while a row or the solve is in work. Depends on tds_pkg and tds_div.
module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sub_diag[31:0], main_diag[63:32], super_diag[95:64], rhs_value[127:96]
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // last_row
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // solution[31:0], row_index[37:32], zero pad [39:38]
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast,   // last_result
    output logic [1:0]   m_axis_tuser    // error_code
);
    import tds_pkg::*;

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RDST   = 5'd1;
    localparam logic [4:0] ST_RDIV   = 5'd2;
    localparam logic [4:0] ST_RMULU  = 5'd3;
    localparam logic [4:0] ST_RRNDU  = 5'd4;
    localparam logic [4:0] ST_RSUBU  = 5'd5;
    localparam logic [4:0] ST_RMULF  = 5'd6;
    localparam logic [4:0] ST_RRNDF  = 5'd7;
    localparam logic [4:0] ST_RSUBF  = 5'd8;
    localparam logic [4:0] ST_RSTORE = 5'd9;
    localparam logic [4:0] ST_BINIT  = 5'd10;
    localparam logic [4:0] ST_BRD    = 5'd11;
    localparam logic [4:0] ST_BMUL   = 5'd12;
    localparam logic [4:0] ST_BRND   = 5'd13;
    localparam logic [4:0] ST_BSUB   = 5'd14;
    localparam logic [4:0] ST_BDIV   = 5'd15;
    localparam logic [4:0] ST_BWAIT  = 5'd16;
    localparam logic [4:0] ST_BOUT   = 5'd17;

    logic [4:0]               state_reg;
    logic [CW-1:0]            row_cnt_reg;
    logic [ERR_W-1:0]         err_reg;
    logic [ERR_W-1:0]         code_reg;
    logic [IW-1:0]            idx_reg;
    logic                     first_reg;

    logic signed [DATA_W-1:0] sub_reg, main_reg, sup_reg, rhs_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] m_reg, piv_reg, fwd_reg, x_reg, num_reg, rnd_reg;
    logic signed [DATA_W-1:0] prev_piv_reg, prev_upper_reg, prev_fwd_reg;
    logic signed [2*DATA_W-1:0] prod_reg;

    logic signed [DATA_W-1:0] pivot_mem   [MAX_ROWS];
    logic signed [DATA_W-1:0] upper_mem   [MAX_ROWS];
    logic signed [DATA_W-1:0] forward_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] piv_rd_reg, upper_rd_reg, fwd_rd_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_sol_reg;
    logic [ROW_IDX_W-1:0]     out_idx_reg;
    logic                     out_last_reg;
    logic [ERR_W-1:0]         out_code_reg;

    logic                     in_xfer;
    logic                     out_load;
    logic [CW-1:0]            cnt_m1;
    logic [IW-1:0]            widx;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     div_start;
    logic signed [DATA_W-1:0] div_num, div_den;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_BOUT) && (!out_valid_reg || m_axis_tready);
    assign cnt_m1        = row_cnt_reg - CW'(1);
    assign widx          = row_cnt_reg[IW-1:0];

    always_comb
    begin
        mul_a = m_reg;
        mul_b = prev_upper_reg;
        if (state_reg == ST_RMULF)
            mul_b = prev_fwd_reg;
        else if (state_reg == ST_BMUL)
        begin
            mul_a = upper_rd_reg;
            mul_b = x_reg;
        end
    end

    assign div_start = (state_reg == ST_RDST) || (state_reg == ST_BDIV);
    assign div_num   = (state_reg == ST_RDST) ? sub_reg : num_reg;
    assign div_den   = (state_reg == ST_RDST) ? prev_piv_reg : piv_rd_reg;

    tds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (row_cnt_reg >= CW'(MAX_ROWS))
                        begin
                            err_reg[1] <= 1'b1;
                            state_reg  <= s_axis_tlast ? ST_BINIT : ST_IDLE;
                        end
                        else if (row_cnt_reg == '0)
                            state_reg <= ST_RSTORE;
                        else
                            state_reg <= ST_RDST;
                    end
                end
                ST_RDST:  state_reg <= ST_RDIV;
                ST_RDIV:  if (div_done) state_reg <= ST_RMULU;
                ST_RMULU: state_reg <= ST_RRNDU;
                ST_RRNDU: state_reg <= ST_RSUBU;
                ST_RSUBU: state_reg <= ST_RMULF;
                ST_RMULF: state_reg <= ST_RRNDF;
                ST_RRNDF: state_reg <= ST_RSUBF;
                ST_RSUBF: state_reg <= ST_RSTORE;
                ST_RSTORE:
                begin
                    if (piv_reg == '0)
                        err_reg[0] <= 1'b1;
                    row_cnt_reg <= row_cnt_reg + CW'(1);
                    state_reg   <= last_reg ? ST_BINIT : ST_IDLE;
                end
                ST_BINIT: state_reg <= ST_BRD;
                ST_BRD:   state_reg <= ST_BMUL;
                ST_BMUL:  state_reg <= first_reg ? ST_BDIV : ST_BRND;
                ST_BRND:  state_reg <= ST_BSUB;
                ST_BSUB:  state_reg <= ST_BDIV;
                ST_BDIV:  state_reg <= ST_BWAIT;
                ST_BWAIT: if (div_done) state_reg <= ST_BOUT;
                ST_BOUT:
                begin
                    if (out_load)
                    begin
                        if (idx_reg == '0)
                        begin
                            row_cnt_reg <= '0;
                            err_reg     <= '0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_BRD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sub_reg  <= s_axis_tdata[31:0];
            main_reg <= s_axis_tdata[63:32];
            sup_reg  <= s_axis_tdata[95:64];
            rhs_reg  <= s_axis_tdata[127:96];
            last_reg <= s_axis_tlast;
            piv_reg  <= s_axis_tdata[63:32];
            fwd_reg  <= s_axis_tdata[127:96];
        end
        prod_reg <= (2*DATA_W)'(mul_a) * (2*DATA_W)'(mul_b);
        if (state_reg == ST_RRNDU || state_reg == ST_RRNDF || state_reg == ST_BRND)
            rnd_reg <= round_mul(prod_reg, FRAC_BITS);
        if (state_reg == ST_RDIV && div_done)
            m_reg <= div_quo;
        if (state_reg == ST_RSUBU)
            piv_reg <= sat_sub(main_reg, rnd_reg);
        if (state_reg == ST_RSUBF)
            fwd_reg <= sat_sub(rhs_reg, rnd_reg);
        if (state_reg == ST_RSTORE)
        begin
            prev_piv_reg   <= piv_reg;
            prev_upper_reg <= sup_reg;
            prev_fwd_reg   <= fwd_reg;
        end
        if (state_reg == ST_BINIT)
        begin
            idx_reg   <= cnt_m1[IW-1:0];
            first_reg <= 1'b1;
            code_reg  <= err_reg[1] ? ERR_ROWS : (err_reg[0] ? ERR_PIVOT : ERR_OK);
        end
        if (state_reg == ST_BMUL)
            num_reg <= fwd_rd_reg;
        if (state_reg == ST_BSUB)
            num_reg <= sat_sub(fwd_rd_reg, rnd_reg);
        if (state_reg == ST_BWAIT && div_done)
            x_reg <= div_quo;
        if (out_load)
        begin
            out_sol_reg  <= x_reg;
            out_idx_reg  <= ROW_IDX_W'(idx_reg);
            out_last_reg <= (idx_reg == '0);
            out_code_reg <= code_reg;
            idx_reg      <= idx_reg - 1'b1;
            first_reg    <= 1'b0;
        end
    end

    // row stores
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RSTORE)
        begin
            pivot_mem[widx]   <= piv_reg;
            upper_mem[widx]   <= sup_reg;
            forward_mem[widx] <= fwd_reg;
        end
        piv_rd_reg   <= pivot_mem[idx_reg];
        upper_rd_reg <= upper_mem[idx_reg];
        fwd_rd_reg   <= forward_mem[idx_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_idx_reg, out_sol_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_code_reg;

    ap_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= CW'(MAX_ROWS)) else $error("row count beyond capacity");
    ap_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RDIV || state_reg == ST_BWAIT))
        else $error("divider result with nobody waiting");
    ap_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> out_idx_reg == '0)
        else $error("final solution not at index zero");
    ap_solve_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && idx_reg == '0 |=> row_cnt_reg == '0 && err_reg == '0)
        else $error("system state not cleared after solve");

endmodule
